// File: rtl/llsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llsa_pkg
// Shared constants and types for the least-loaded server assignment block.
// ----------------------------------------------------------------------------
package llsa_pkg;

    localparam int MAX_CASHIERS = 16;
    localparam int IDX_W        = $clog2(MAX_CASHIERS);
    localparam int CNT_W        = $clog2(MAX_CASHIERS + 1);
    localparam int CFG_W        = 5;
    localparam int RATE_W       = 8;
    localparam int ITEM_W       = 8;
    localparam int TIME_W       = 32;
    localparam int PROD_W       = RATE_W + ITEM_W;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(MAX_CASHIERS);

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_JOB  = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_LAST = 6'b000100,
        S_RATE = 6'b001000,
        S_MUL  = 6'b010000,
        S_ADD  = 6'b100000
    } state_t;

endpackage

// File: rtl/llsa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llsa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module llsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/least_loaded_server_assign.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_loaded_server_assign
// Greedy assignment of jobs to the active server with the smallest busy time.
// ----------------------------------------------------------------------------
// A load word is taken without going busy, and its result strobes on done in
// the next cycle. A job word keeps busy high until its result is formed; the
// scan covers the N effective active servers (1..16), reading one busy-time
// entry per cycle through the single read port of the busy-time RAM, and then
// the block reads the rate, multiplies, adds and writes back. Each
// result is shown for exactly one cycle with done high; the receiver cannot
// stall it, and a new word may be started in that same cycle.
// ----------------------------------------------------------------------------
module least_loaded_server_assign (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           req_type,
    input  logic [llsa_pkg::IDX_W-1:0]     cashier_index,
    input  logic [llsa_pkg::RATE_W-1:0]    rate,
    input  logic [llsa_pkg::ITEM_W-1:0]    item_count,
    input  logic                           cfg_we,
    input  logic [llsa_pkg::CFG_W-1:0]     cfg_wdata,
    output logic                           done,
    output logic [llsa_pkg::IDX_W-1:0]     assigned_cashier,
    output logic [llsa_pkg::TIME_W-1:0]    finish_time,
    output logic [llsa_pkg::TIME_W-1:0]    longest_finish,
    output logic                           index_ignored
);

    localparam int IDX_W  = llsa_pkg::IDX_W;
    localparam int CNT_W  = llsa_pkg::CNT_W;
    localparam int CFG_W  = llsa_pkg::CFG_W;
    localparam int RATE_W = llsa_pkg::RATE_W;
    localparam int ITEM_W = llsa_pkg::ITEM_W;
    localparam int TIME_W = llsa_pkg::TIME_W;
    localparam int PROD_W = llsa_pkg::PROD_W;
    localparam int MAXC   = llsa_pkg::MAX_CASHIERS;

    llsa_pkg::state_t state_reg, state_next;

    logic [CFG_W-1:0]  active_cashiers_reg;
    logic [MAXC-1:0]   vld_reg, vld_next;
    logic [MAXC-1:0]   rate_vld_reg, rate_vld_next;
    logic              busy_vq_reg, busy_vq_next;
    logic              rate_vq_reg, rate_vq_next;
    logic [ITEM_W-1:0] items_reg, items_next;
    logic [IDX_W-1:0]  last_reg, last_next;
    logic [IDX_W-1:0]  scan_reg, scan_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic [TIME_W-1:0] min_reg, min_next;
    logic [IDX_W-1:0]  chosen_reg, chosen_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [TIME_W-1:0] longest_reg, longest_next;
    logic              done_reg, done_next;
    logic [IDX_W-1:0]  assigned_reg, assigned_next;
    logic [TIME_W-1:0] finish_reg, finish_next;
    logic [TIME_W-1:0] lf_reg, lf_next;
    logic              ignored_reg, ignored_next;

    logic              busy_we;
    logic [IDX_W-1:0]  busy_waddr;
    logic [TIME_W-1:0] busy_wdata;
    logic [IDX_W-1:0]  busy_raddr;
    logic [TIME_W-1:0] busy_rdata;
    logic              rate_we;
    logic [RATE_W-1:0] rate_rdata;

    logic [CNT_W-1:0]  n_eff;
    logic              accept;
    logic              load_ok;
    logic [TIME_W-1:0] busy_rd;
    logic [RATE_W-1:0] rate_rd;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] fin;

    llsa_ram #(.WIDTH(TIME_W), .DEPTH(MAXC)) u_busy_ram (
        .clk   (clk),
        .we    (busy_we),
        .waddr (busy_waddr),
        .wdata (busy_wdata),
        .raddr (busy_raddr),
        .rdata (busy_rdata)
    );

    llsa_ram #(.WIDTH(RATE_W), .DEPTH(MAXC)) u_rate_ram (
        .clk   (clk),
        .we    (rate_we),
        .waddr (cashier_index),
        .wdata (rate),
        .raddr (chosen_reg),
        .rdata (rate_rdata)
    );

    always_comb
    begin
        if (active_cashiers_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (CNT_W'(active_cashiers_reg) > CNT_W'(MAXC))
        begin
            n_eff = CNT_W'(MAXC);
        end
        else
        begin
            n_eff = CNT_W'(active_cashiers_reg);
        end
    end

    assign busy    = (state_reg != llsa_pkg::S_IDLE);
    assign accept  = start && !busy;
    assign load_ok = (CNT_W'(cashier_index) < n_eff);
    assign busy_rd = busy_vq_reg ? busy_rdata : '0;
    assign rate_rd = rate_vq_reg ? rate_rdata : '0;
    assign sum     = {1'b0, min_reg} + (TIME_W + 1)'(prod_reg);
    assign fin     = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        vld_next      = vld_reg;
        rate_vld_next = rate_vld_reg;
        items_next    = items_reg;
        last_next     = last_reg;
        scan_next     = scan_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        min_next      = min_reg;
        chosen_next   = chosen_reg;
        prod_next     = prod_reg;
        longest_next  = longest_reg;
        done_next     = 1'b0;
        assigned_next = assigned_reg;
        finish_next   = finish_reg;
        lf_next       = lf_reg;
        ignored_next  = ignored_reg;
        busy_we       = 1'b0;
        busy_waddr    = cashier_index;
        busy_wdata    = '0;
        busy_raddr    = scan_reg;
        rate_we       = 1'b0;

        // fold in the busy time read during the previous cycle
        if (cmp_vld_reg && ((cmp_idx_reg == '0) || (busy_rd < min_reg)))
        begin
            min_next    = busy_rd;
            chosen_next = cmp_idx_reg;
        end

        case (state_reg)
            llsa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == llsa_pkg::REQ_LOAD)
                    begin
                        assigned_next = cashier_index;
                        finish_next   = '0;
                        ignored_next  = !load_ok;
                        lf_next       = longest_reg;
                        done_next     = 1'b1;
                        if (load_ok)
                        begin
                            busy_we                      = 1'b1;
                            rate_we                      = 1'b1;
                            vld_next[cashier_index]      = 1'b1;
                            rate_vld_next[cashier_index] = 1'b1;
                            if (cashier_index == '0)
                            begin
                                longest_next = '0;
                                lf_next      = '0;
                            end
                        end
                    end
                    else
                    begin
                        items_next = item_count;
                        last_next  = IDX_W'(n_eff - CNT_W'(1));
                        scan_next  = '0;
                        state_next = llsa_pkg::S_SCAN;
                    end
                end
            end
            llsa_pkg::S_SCAN:
            begin
                cmp_vld_next = 1'b1;
                cmp_idx_next = scan_reg;
                if (scan_reg == last_reg)
                begin
                    state_next = llsa_pkg::S_LAST;
                end
                else
                begin
                    scan_next = scan_reg + IDX_W'(1);
                end
            end
            llsa_pkg::S_LAST:
            begin
                state_next = llsa_pkg::S_RATE;
            end
            llsa_pkg::S_RATE:
            begin
                state_next = llsa_pkg::S_MUL;
            end
            llsa_pkg::S_MUL:
            begin
                prod_next  = PROD_W'(rate_rd) * PROD_W'(items_reg);
                state_next = llsa_pkg::S_ADD;
            end
            llsa_pkg::S_ADD:
            begin
                busy_we       = 1'b1;
                busy_waddr    = chosen_reg;
                busy_wdata    = fin;
                vld_next[chosen_reg] = 1'b1;
                if (fin > longest_reg)
                begin
                    longest_next = fin;
                    lf_next      = fin;
                end
                else
                begin
                    lf_next = longest_reg;
                end
                assigned_next = chosen_reg;
                finish_next   = fin;
                ignored_next  = 1'b0;
                done_next     = 1'b1;
                state_next    = llsa_pkg::S_IDLE;
            end
            default:
            begin
                state_next = llsa_pkg::S_IDLE;
            end
        endcase

        busy_vq_next = vld_reg[busy_raddr];
        rate_vq_next = rate_vld_reg[chosen_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= llsa_pkg::S_IDLE;
            active_cashiers_reg <= llsa_pkg::ACTIVE_RESET;
            vld_reg             <= '0;
            rate_vld_reg        <= '0;
            busy_vq_reg         <= 1'b0;
            rate_vq_reg         <= 1'b0;
            cmp_vld_reg         <= 1'b0;
            longest_reg         <= '0;
            done_reg            <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            vld_reg      <= vld_next;
            rate_vld_reg <= rate_vld_next;
            busy_vq_reg  <= busy_vq_next;
            rate_vq_reg  <= rate_vq_next;
            cmp_vld_reg  <= cmp_vld_next;
            longest_reg  <= longest_next;
            done_reg     <= done_next;
            if (cfg_we)
            begin
                active_cashiers_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        items_reg    <= items_next;
        last_reg     <= last_next;
        scan_reg     <= scan_next;
        cmp_idx_reg  <= cmp_idx_next;
        min_reg      <= min_next;
        chosen_reg   <= chosen_next;
        prod_reg     <= prod_next;
        assigned_reg <= assigned_next;
        finish_reg   <= finish_next;
        lf_reg       <= lf_next;
        ignored_reg  <= ignored_next;
    end

    assign done             = done_reg;
    assign assigned_cashier = assigned_reg;
    assign finish_time      = finish_reg;
    assign longest_finish   = lf_reg;
    assign index_ignored    = ignored_reg;

endmodule

// File: sim/least_loaded_server_assign_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_loaded_server_assign_test
// Self-checking bench for the least-loaded server assignment block. Load and
// job words are started with random sender gaps, each accepted word is run
// through a behavioral predictor of the server tables, and every strobed
// result is compared field by field with the oldest prediction. Directed
// words cover ties, ignored loads and makespan clearing; random phases
// follow under several active-count settings.
// ----------------------------------------------------------------------------
module least_loaded_server_assign_test;

    localparam int IDX_W        = llsa_pkg::IDX_W;
    localparam int CFG_W        = llsa_pkg::CFG_W;
    localparam int RATE_W       = llsa_pkg::RATE_W;
    localparam int ITEM_W       = llsa_pkg::ITEM_W;
    localparam int TIME_W       = llsa_pkg::TIME_W;
    localparam int MAX_CASHIERS = llsa_pkg::MAX_CASHIERS;

    typedef struct {
        logic [IDX_W-1:0]  cashier;
        logic [TIME_W-1:0] finish;
        logic [TIME_W-1:0] longest;
        logic              ignored;
    } assignment_t;

    class assignment_scoreboard;
        logic [RATE_W-1:0] rate_tab [MAX_CASHIERS];
        logic [TIME_W-1:0] busy_tab [MAX_CASHIERS];
        logic [TIME_W-1:0] makespan;
        logic [CFG_W-1:0]  active_reg;
        assignment_t       expected_assignments [$];
        int                errors;

        function new();
            foreach (rate_tab[k])
            begin
                rate_tab[k] = '0;
                busy_tab[k] = '0;
            end
            makespan   = '0;
            active_reg = llsa_pkg::ACTIVE_RESET;
            errors     = 0;
        endfunction

        function int unsigned served_count();
            if (active_reg < 1)
                return 1;
            if (active_reg > MAX_CASHIERS)
                return MAX_CASHIERS;
            return 32'(active_reg);
        endfunction

        function void predict_assignment(logic req, logic [IDX_W-1:0] idx,
                                         logic [RATE_W-1:0] rt, logic [ITEM_W-1:0] items);
            assignment_t exp_w;
            int unsigned n;
            int unsigned k;
            logic [63:0] total;
            n             = served_count();
            exp_w.cashier = idx;
            exp_w.finish  = '0;
            exp_w.ignored = 1'b0;
            if (req == llsa_pkg::REQ_LOAD)
            begin
                if (idx >= n)
                    exp_w.ignored = 1'b1;
                else
                begin
                    rate_tab[idx] = rt;
                    busy_tab[idx] = '0;
                    if (idx == 0)
                        makespan = '0;
                end
            end
            else
            begin
                exp_w.cashier = '0;
                for (k = 1; k < n; k++)
                begin
                    if (busy_tab[k] < busy_tab[exp_w.cashier])
                        exp_w.cashier = k[IDX_W-1:0];
                end
                total = 64'(busy_tab[exp_w.cashier])
                      + 64'(rate_tab[exp_w.cashier]) * 64'(items);
                if (total > 64'hFFFF_FFFF)
                    total = 64'hFFFF_FFFF;
                exp_w.finish = total[TIME_W-1:0];
                busy_tab[exp_w.cashier] = exp_w.finish;
                if (exp_w.finish > makespan)
                    makespan = exp_w.finish;
            end
            exp_w.longest = makespan;
            expected_assignments.push_back(exp_w);
        endfunction

        function void report_field(string name, logic [TIME_W-1:0] e, logic [TIME_W-1:0] a);
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, e, a);
        endfunction

        function void check_assignment(logic [IDX_W-1:0] a_cashier, logic [TIME_W-1:0] a_finish,
                                       logic [TIME_W-1:0] a_longest, logic a_ignored);
            assignment_t exp_w;
            if (expected_assignments.size() == 0)
            begin
                errors++;
                $display("%0t: expected no word, got cashier %0d finish %0d longest %0d",
                         $time, a_cashier, a_finish, a_longest);
                return;
            end
            exp_w = expected_assignments.pop_front();
            if (a_cashier !== exp_w.cashier)
                report_field("assigned_cashier", TIME_W'(exp_w.cashier), TIME_W'(a_cashier));
            if (a_finish !== exp_w.finish)
                report_field("finish_time", exp_w.finish, a_finish);
            if (a_longest !== exp_w.longest)
                report_field("longest_finish", exp_w.longest, a_longest);
            if (a_ignored !== exp_w.ignored)
                report_field("index_ignored", TIME_W'(exp_w.ignored), TIME_W'(a_ignored));
        endfunction
    endclass

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              start         = 1'b0;
    logic              busy;
    logic              req_type      = llsa_pkg::REQ_LOAD;
    logic [IDX_W-1:0]  cashier_index = '0;
    logic [RATE_W-1:0] rate          = '0;
    logic [ITEM_W-1:0] item_count    = '0;
    logic              cfg_we        = 1'b0;
    logic [CFG_W-1:0]  cfg_wdata     = '0;
    logic              done;
    logic [IDX_W-1:0]  assigned_cashier;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] longest_finish;
    logic              index_ignored;

    assignment_scoreboard board;

    least_loaded_server_assign u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .req_type         (req_type),
        .cashier_index    (cashier_index),
        .rate             (rate),
        .item_count       (item_count),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .done             (done),
        .assigned_cashier (assigned_cashier),
        .finish_time      (finish_time),
        .longest_finish   (longest_finish),
        .index_ignored    (index_ignored)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done !== 1'b0)
            board.check_assignment(assigned_cashier, finish_time, longest_finish,
                                   index_ignored);
    end

    task automatic send_word(logic req, logic [IDX_W-1:0] idx, logic [RATE_W-1:0] rt,
                             logic [ITEM_W-1:0] items);
        start         <= 1'b1;
        req_type      <= req;
        cashier_index <= idx;
        rate          <= rt;
        item_count    <= items;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        board.predict_assignment(req, idx, rt, items);
    endtask

    task automatic pause_sender(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (board.expected_assignments.size() != 0);
    endtask

    task automatic write_active(logic [CFG_W-1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.active_reg = value;
    endtask

    task automatic send_random(bit gaps);
        logic [RATE_W-1:0] rt;
        logic [ITEM_W-1:0] items;
        logic [IDX_W-1:0]  idx;
        if (gaps && $urandom_range(0, 3) == 0)
            pause_sender(int'($urandom_range(1, 10)));
        rt    = RATE_W'($urandom_range(0, 255));
        items = ITEM_W'($urandom_range(0, 255));
        idx   = IDX_W'($urandom_range(0, MAX_CASHIERS - 1));
        if ($urandom_range(0, 7) == 0)
            rt = $urandom_range(0, 1) ? '1 : '0;
        if ($urandom_range(0, 7) == 0)
            items = $urandom_range(0, 1) ? '1 : '0;
        if ($urandom_range(0, 3) == 0)
            send_word(llsa_pkg::REQ_LOAD, idx, rt, items);
        else
            send_word(llsa_pkg::REQ_JOB, idx, rt, items);
    endtask

    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        logic [CFG_W-1:0] settings [8];
        int               n;
        board    = new();
        settings = '{5'd16, 5'd1, 5'd31, 5'd2, 5'd0, 5'd5, 5'd17, 5'd0};
        settings[7] = CFG_W'($urandom_range(0, 31));
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(llsa_pkg::REQ_JOB, 4'd15, 8'd255, 8'd255);
        send_word(llsa_pkg::REQ_LOAD, 4'd15, 8'd255, 8'd255);
        send_word(llsa_pkg::REQ_LOAD, 4'd0, 8'd1, 8'd0);
        pause_sender(3);
        send_word(llsa_pkg::REQ_JOB, 4'd0, 8'd0, 8'd0);
        send_word(llsa_pkg::REQ_JOB, 4'd0, 8'd0, 8'd255);
        send_word(llsa_pkg::REQ_LOAD, 4'd5, 8'd0, 8'd0);

        write_active(5'd2);
        send_word(llsa_pkg::REQ_LOAD, 4'd0, 8'd255, 8'd0);
        send_word(llsa_pkg::REQ_LOAD, 4'd1, 8'd255, 8'd0);
        send_word(llsa_pkg::REQ_LOAD, 4'd9, 8'd3, 8'd0);
        send_word(llsa_pkg::REQ_LOAD, 4'd2, 8'd0, 8'd0);
        send_word(llsa_pkg::REQ_JOB, 4'd0, 8'd0, 8'd255);
        send_word(llsa_pkg::REQ_JOB, 4'd0, 8'd0, 8'd255);
        pause_sender(7);
        send_word(llsa_pkg::REQ_JOB, 4'd0, 8'd0, 8'd1);
        send_word(llsa_pkg::REQ_JOB, 4'd0, 8'd0, 8'd0);
        send_word(llsa_pkg::REQ_LOAD, 4'd1, 8'd7, 8'd0);
        send_word(llsa_pkg::REQ_LOAD, 4'd0, 8'd200, 8'd0);
        send_word(llsa_pkg::REQ_JOB, 4'd0, 8'd0, 8'd17);

        // keep server 0 as the only active server
        write_active(5'd0);
        send_word(llsa_pkg::REQ_LOAD, 4'd1, 8'd9, 8'd0);
        send_word(llsa_pkg::REQ_LOAD, 4'd0, 8'd255, 8'd0);
        repeat (4)
            send_word(llsa_pkg::REQ_JOB, IDX_W'($urandom_range(0, 15)),
                      RATE_W'($urandom_range(0, 255)), 8'd255);
        send_word(llsa_pkg::REQ_JOB, 4'd0, 8'd0, 8'd0);

        write_active(5'd31);
        send_word(llsa_pkg::REQ_JOB, 4'd0, 8'd0, 8'd3);
        send_word(llsa_pkg::REQ_LOAD, 4'd15, 8'd255, 8'd0);
        send_word(llsa_pkg::REQ_JOB, 4'd0, 8'd0, 8'd200);

        foreach (settings[p])
        begin
            write_active(settings[p]);
            n = int'(board.served_count());
            for (int k = 0; k < n; k++)
                send_word(llsa_pkg::REQ_LOAD, IDX_W'(k), RATE_W'($urandom_range(0, 255)),
                          ITEM_W'($urandom_range(0, 255)));
            repeat (40)
                send_random(p != 7);
        end

        drain_results();
        repeat (40) @(posedge clk);
        if (board.errors == 0 && board.expected_assignments.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
